FILE: rtl/crcc_pkg.sv
// Shared constants and types for the CRC-16 chunk checker.
// No dependencies; compiled first.
package crcc_pkg;

   localparam int unsigned CRC_W   = 16;
   localparam int unsigned BYTE_W  = 8;

   typedef logic [CRC_W-1:0]  crc_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam crc_type CRC_POLY   = 16'h1021;
   localparam crc_type SEED_RESET = 16'hBEEF;

endpackage

FILE: rtl/crcc_if.sv
// Valid/ready channel interfaces for the chunk checker: request, response, csr.
// Depends on crcc_pkg.
interface crcc_req_if import crcc_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;
   crc_type  expected_crc;

   modport source (output valid, data_byte, last_byte, expected_crc, input ready);
   modport sink   (input valid, data_byte, last_byte, expected_crc, output ready);
endinterface

interface crcc_rsp_if import crcc_pkg::*; ();
   logic    valid;
   logic    ready;
   crc_type crc_value;
   logic    crc_match;

   modport source (output valid, crc_value, crc_match, input ready);
   modport sink   (input valid, crc_value, crc_match, output ready);
endinterface

interface crcc_csr_if import crcc_pkg::*; ();
   logic    valid;
   logic    ready;
   crc_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/crcc_update.sv
// One-byte MSB-first CRC-16 update, no reflection, no final XOR.
// Depends on crcc_pkg.
module crcc_update import crcc_pkg::*; (
   input  crc_type  crc_cur,
   input  byte_type data_byte,
   output crc_type  crc_next
);

   always_comb begin
      crc_type c;
      c = crc_cur ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

FILE: rtl/crc16_chunk_checker.sv
// CRC-16 (poly 0x1021, MSB first) chunk checker. Accepts one byte beat per
// cycle, so throughput is one byte per cycle, unless a last byte waits on a
// stalled response; the byte update and compare sit between the input
// register and the response register, which holds the response beat. A
// stalled response holds only a last byte in the input register. Each chunk
// starts from the seed register (reset 0xBEEF); writing the seed also
// restarts the running CRC. Only a chunk's last byte makes a response beat.
// Depends on crcc_pkg, crcc_if, crcc_update.
module crc16_chunk_checker import crcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   crcc_req_if.sink   req_chan,
   crcc_rsp_if.source rsp_chan,
   crcc_csr_if.sink   csr_chan
);

   crc_type  seed_ff, seed_in;
   crc_type  crc_ff, crc_in;
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;
   logic     s1_last_ff;
   crc_type  s1_exp_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   crc_type  rsp_crc_ff;
   logic     rsp_match_ff;

   crc_type  crc_next;
   logic     req_acc, csr_acc, out_free, s1_go;

   crcc_update u_update (
      .crc_cur   (crc_ff),
      .data_byte (s1_byte_ff),
      .crc_next  (crc_next)
   );

   assign csr_chan.ready = 1'b1;
   assign csr_acc        = csr_chan.valid;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_comb begin
      seed_in = seed_ff;
      crc_in  = crc_ff;
      if (s1_go) begin
         crc_in = s1_last_ff ? seed_ff : crc_next;
      end
      if (csr_acc) begin
         seed_in = csr_chan.data;
         crc_in  = csr_chan.data;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         crc_ff       <= SEED_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         crc_ff       <= crc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
         s1_exp_ff  <= req_chan.expected_crc;
      end
      if (s1_go && s1_last_ff) begin
         rsp_crc_ff   <= crc_next;
         rsp_match_ff <= (crc_next == s1_exp_ff);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.crc_value = rsp_crc_ff;
   assign rsp_chan.crc_match = rsp_match_ff;

   a_reset_seed: assert property (@(posedge clock)
      reset |=> (crc_ff == SEED_RESET && seed_ff == SEED_RESET))
      else $error("running crc not at seed after reset");

   a_csr_load: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> (crc_ff == $past(csr_chan.data) && seed_ff == $past(csr_chan.data)))
      else $error("seed write did not load running crc");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response without a last byte");

   a_chunk_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff && !csr_acc) |=> (crc_ff == seed_ff))
      else $error("crc not reloaded after last byte");

endmodule
